>>> design/sddf_pkg.sv
package sddf_pkg;

    // magnitude, cell, symbol, point and field widths
    localparam int VALUE_W  = 32;
    localparam int CELL_W   = 10;
    localparam int SYMBOL_W = 4;
    localparam int POINT_W  = 6;
    localparam int FIELD_W  = 5;

    typedef logic [SYMBOL_W-1:0] t_symbol;

    // symbol codes above the ten digits
    localparam t_symbol SYM_PLUS  = 4'd10;
    localparam t_symbol SYM_MINUS = 4'd11;
    localparam t_symbol SYM_DOT   = 4'd12;
    localparam t_symbol SYM_BLANK = 4'd13;

    // reciprocal of ten, exact for every 32-bit dividend with a shift of 35
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

endpackage

>>> design/signed_decimal_display_formatter.sv
// the first cell passes the S_DIGIT state and the output registers, then one cell per cycle
// an item writing n cells (1 to MAX_WIDTH + 1) holds busy while its cells are produced,
// so a new request is taken only once the sequencer is back in S_IDLE
// each cell is a digit from the shared divide-by-ten unit, a dot, or one sign/blank step
// reset: synchronous, active low; clears the sequencer and the output strobe
// the receiver cannot stall: every cell is shown for exactly one cycle
module signed_decimal_display_formatter import sddf_pkg::*; #(
    parameter int MAX_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [CELL_W-1:0]          i_anchor_cell,
    input  logic [FIELD_W-1:0]         i_field_width,
    input  logic signed [POINT_W-1:0]  i_point_position,
    input  logic                       i_show_plus,
    output logic                       o_strobe,
    output logic [CELL_W-1:0]          o_cell_res,
    output logic [SYMBOL_W-1:0]        o_symbol,
    output logic                       o_last
);

    localparam int WW = $clog2(MAX_WIDTH + 1) + 1;
    localparam logic signed [WW-1:0] ONE_W  = WW'(1);
    localparam logic signed [WW-1:0] ZERO_W = WW'(0);
    localparam logic signed [POINT_W-1:0] ZERO_P = POINT_W'(0);
    localparam logic signed [POINT_W-1:0] ONE_P  = POINT_W'(1);

    typedef enum logic [1:0] {S_IDLE, S_DIGIT, S_SIGN, S_BLANK} t_state;

    t_state                     r_state, n_state;
    logic [VALUE_W-1:0]         r_mag, n_mag;
    logic signed [WW-1:0]       r_width, n_width;
    logic signed [POINT_W-1:0]  r_point, n_point;
    logic [CELL_W-1:0]          r_cell, n_cell;
    logic                       r_has_sign, n_has_sign;
    t_symbol                    r_sign_sym, n_sign_sym;
    logic                       r_strobe, n_strobe;
    logic [CELL_W-1:0]          r_cell_out, n_cell_out;
    t_symbol                    r_symbol, n_symbol;
    logic                       r_last, n_last;

    logic [VALUE_W-1:0]         w_quot;
    logic [SYMBOL_W-1:0]        w_rem;
    logic [VALUE_W-1:0]         w_raw;
    logic signed [WW-1:0]       w_width_dec;
    logic [VALUE_W-1:0]         w_mag_next;

    // shared divide-by-ten unit working on the held magnitude
    sddf_div10 u_div10 (
        .i_dividend  (r_mag),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    assign w_raw       = i_value;
    assign w_width_dec = r_width - ONE_W;

    // sequencer next-state and cell generation
    always_comb begin
        n_state    = r_state;
        n_mag      = r_mag;
        n_width    = r_width;
        n_point    = r_point;
        n_cell     = r_cell;
        n_has_sign = r_has_sign;
        n_sign_sym = r_sign_sym;
        n_strobe   = 1'b0;
        n_cell_out = r_cell_out;
        n_symbol   = r_symbol;
        n_last     = r_last;
        w_mag_next = r_mag;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mag   = w_raw[VALUE_W-1] ? (VALUE_W'(0) - w_raw) : w_raw;
                    if (32'(i_field_width) > 32'(MAX_WIDTH)) begin
                        n_width = WW'(MAX_WIDTH);
                    end else begin
                        n_width = WW'(i_field_width);
                    end
                    n_point    = i_point_position;
                    n_cell     = i_anchor_cell;
                    n_has_sign = w_raw[VALUE_W-1] || (i_show_plus && (w_raw != '0));
                    n_sign_sym = w_raw[VALUE_W-1] ? SYM_MINUS : SYM_PLUS;
                    n_state    = S_DIGIT;
                end
            end
            S_DIGIT: begin
                n_strobe   = 1'b1;
                n_cell_out = r_cell;
                n_cell     = r_cell - CELL_W'(1);
                n_width    = w_width_dec;
                if (r_point == ZERO_P) begin
                    n_symbol   = SYM_DOT;
                    w_mag_next = r_mag;
                end else begin
                    n_symbol   = w_rem;
                    w_mag_next = w_quot;
                end
                n_mag = w_mag_next;
                // point counter holds once it has passed zero
                if (!r_point[POINT_W-1]) begin
                    n_point = r_point - ONE_P;
                end
                n_last = 1'b0;
                if ((w_mag_next != '0) && (w_width_dec > ZERO_W)) begin
                    n_state = S_DIGIT;
                end else if (r_has_sign) begin
                    n_state = S_SIGN;
                end else if (w_width_dec > ZERO_W) begin
                    n_state = S_BLANK;
                end else begin
                    n_state = S_IDLE;
                    n_last  = 1'b1;
                end
            end
            S_SIGN: begin
                n_strobe   = 1'b1;
                n_cell_out = r_cell;
                n_cell     = r_cell - CELL_W'(1);
                n_width    = w_width_dec;
                n_symbol   = r_sign_sym;
                if (w_width_dec > ZERO_W) begin
                    n_state = S_BLANK;
                    n_last  = 1'b0;
                end else begin
                    n_state = S_IDLE;
                    n_last  = 1'b1;
                end
            end
            S_BLANK: begin
                n_strobe   = 1'b1;
                n_cell_out = r_cell;
                n_cell     = r_cell - CELL_W'(1);
                n_width    = w_width_dec;
                n_symbol   = SYM_BLANK;
                if (w_width_dec > ZERO_W) begin
                    n_state = S_BLANK;
                    n_last  = 1'b0;
                end else begin
                    n_state = S_IDLE;
                    n_last  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, working registers and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_strobe   <= n_strobe;
            r_mag      <= n_mag;
            r_width    <= n_width;
            r_point    <= n_point;
            r_cell     <= n_cell;
            r_has_sign <= n_has_sign;
            r_sign_sym <= n_sign_sym;
            r_cell_out <= n_cell_out;
            r_symbol   <= n_symbol;
            r_last     <= n_last;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_cell_res = r_cell_out;
    assign o_symbol   = r_symbol;
    assign o_last     = r_last;

endmodule

>>> design/sddf_div10.sv
module sddf_div10 import sddf_pkg::*; (
    input  logic [VALUE_W-1:0]  i_dividend,
    output logic [VALUE_W-1:0]  o_quotient,
    output logic [SYMBOL_W-1:0] o_remainder
);

    logic [2*VALUE_W-1:0] w_product;
    logic [VALUE_W-1:0]   w_times_ten;
    logic [VALUE_W-1:0]   w_rem_full;

    // quotient by reciprocal multiply and shift
    assign w_product  = (2*VALUE_W)'(i_dividend) * (2*VALUE_W)'(RECIP_TEN);
    assign o_quotient = VALUE_W'(w_product >> RECIP_SHIFT);

    // remainder by shift-add back-multiply and subtract
    assign w_times_ten = (o_quotient << 3) + (o_quotient << 1);
    assign w_rem_full  = i_dividend - w_times_ten;
    assign o_remainder = w_rem_full[SYMBOL_W-1:0];

endmodule

>>> design/sddf_checker.sv
module sddf_checker import sddf_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input logic [CELL_W-1:0]   o_cell_res,
    input logic [SYMBOL_W-1:0] o_symbol,
    input logic                o_last
);

    // a taken request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // cells of one request come back to back
    a_cells_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside a result run");

    // block stays busy until the final cell is shown
    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("block idle before final cell");

    // each following cell sits one place to the left
    a_cell_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_cell_res == ($past(o_cell_res) - CELL_W'(1))))
        else $error("cell offset did not step left");

    // only defined symbol codes are written
    a_symbol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_symbol <= SYM_BLANK))
        else $error("undefined symbol code");

endmodule

bind signed_decimal_display_formatter sddf_checker u_sddf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_cell_res (o_cell_res),
    .o_symbol   (o_symbol),
    .o_last     (o_last)
);
